@@ rtl/core/kst_pkg.sv @@
// Package: request and response types and command and status codes of the keyed slot table.
`timescale 1ns / 1ps

package kst_pkg;

	// Command codes
	localparam logic [1:0] CMD_SET       = 2'd0;
	localparam logic [1:0] CMD_GET       = 2'd1;
	localparam logic [1:0] CMD_CLEAR     = 2'd2;
	localparam logic [1:0] CMD_CLEAR_ROW = 2'd3;

	// Status codes
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_BAD_ARG = 2'd1;
	localparam logic [1:0] ST_MISS    = 2'd2;

	typedef struct packed {
		logic [1:0]  command;
		logic [63:0] character_id;
		logic [2:0]  slot;
		logic        choice_enabled;
		logic [31:0] choice_payload;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        read_enabled;
		logic [31:0] read_payload;
	} rsp_t;

endpackage

@@ rtl/core/keyed_slot_table_unit.sv @@
// Top level: keyed slot table with registered row keys and a synchronous payload memory.
`timescale 1ns / 1ps

// Keyed slot table.
// Request channel (req_valid / req_stall / req): one command per request. A
// request is taken when req_valid is high and req_stall is low. Response
// channel (rsp_valid / rsp_stall / rsp): exactly one response per request, in
// order, held in an output register until the receiver drops rsp_stall.
// Sequence: a request is latched, then executed in the execute state (parallel
// compare of the id against all registered row keys, valid-bit update and at
// most one access of the payload memory). Set, clear, clear-row and rejected
// commands load their response into the output register when executed; a get
// that hits an enabled slot first passes through a read state that waits for
// the memory read data. One request is in flight at a time; req_stall is high from
// acceptance until the response is loaded into the output register.
// A stalled response blocks execution of the next request: it waits in the
// execute cycle until the output register is free.
// Reset: all row keys return to zero (free) and all slot enable bits clear at
// once; the payload memory is not cleared, an entry is read only while its
// enable bit is set.
module keyed_slot_table_unit #(
	parameter int ROWS          = 8,
	parameter int SLOTS         = 7,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  kst_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output kst_pkg::rsp_t rsp
);
	import kst_pkg::*;

	localparam int DEPTH = ROWS * SLOTS;
	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_READ = 2'd2;

	logic [1:0]               state_q;
	req_t                     req_s1;
	rsp_t                     rsp_q;
	logic                     rsp_valid_q;
	logic [63:0]              key_q   [ROWS];
	logic [SLOTS-1:0]         valid_q [ROWS];
	logic [PAYLOAD_WIDTH-1:0] mem     [DEPTH];
	logic [PAYLOAD_WIDTH-1:0] mem_rdata_q;

	logic [ROWS-1:0]          hit_vec;
	logic [ROWS-1:0]          free_vec;
	logic                     hit_any;
	logic                     free_any;
	logic [RW-1:0]            hit_row;
	logic [RW-1:0]            free_row;
	logic                     id_zero;
	logic                     slot_ok;
	logic [SLOTS-1:0]         slot_mask;
	logic                     slot_on;

	logic                     out_free;
	logic                     exec_go;
	logic                     rsp_load;
	logic [1:0]               ex_status;
	logic [RW-1:0]            ex_row;
	logic                     key_we;
	logic [63:0]              key_nxt;
	logic                     valid_we;
	logic [SLOTS-1:0]         valid_nxt;
	logic                     mem_we;
	logic                     mem_re;
	logic [AW-1:0]            mem_addr;
	logic [PAYLOAD_WIDTH-1:0] mem_wdata;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign exec_go   = (state_q == S_EXEC) && out_free;
	assign rsp_load  = (exec_go && !mem_re) || (state_q == S_READ);

	// Compare the id against every key; pick the lowest match and the lowest free row
	always_comb begin
		hit_row  = '0;
		free_row = '0;
		for (int r = 0; r < ROWS; r++) begin
			hit_vec[r]  = (key_q[r] == req_s1.character_id);
			free_vec[r] = (key_q[r] == 64'd0);
		end
		for (int r = ROWS - 1; r >= 0; r--) begin
			if (hit_vec[r]) begin
				hit_row = RW'(r);
			end
			if (free_vec[r]) begin
				free_row = RW'(r);
			end
		end
		hit_any  = |hit_vec;
		free_any = |free_vec;
	end

	assign id_zero   = (req_s1.character_id == 64'd0);
	assign slot_ok   = ({29'd0, req_s1.slot} < 32'(SLOTS));
	assign slot_mask = SLOTS'(1) << req_s1.slot;
	assign slot_on   = |(valid_q[hit_row] & slot_mask);
	assign mem_addr  = AW'(AW'(ex_row) * AW'(SLOTS) + AW'(req_s1.slot));
	assign mem_wdata = PAYLOAD_WIDTH'(req_s1.choice_payload);

	// Decode the command against the lookup result
	always_comb begin
		ex_status = ST_DONE;
		ex_row    = hit_row;
		key_we    = 1'b0;
		key_nxt   = req_s1.character_id;
		valid_we  = 1'b0;
		valid_nxt = valid_q[hit_row];
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		if (id_zero) begin
			ex_status = ST_BAD_ARG;
		end else begin
			case (req_s1.command)
				CMD_SET: begin
					if (!slot_ok || !req_s1.choice_enabled) begin
						ex_status = ST_BAD_ARG;
					end else if (hit_any) begin
						valid_we  = 1'b1;
						valid_nxt = valid_q[hit_row] | slot_mask;
						mem_we    = 1'b1;
					end else if (free_any) begin
						ex_row    = free_row;
						key_we    = 1'b1;
						valid_we  = 1'b1;
						valid_nxt = slot_mask;
						mem_we    = 1'b1;
					end else begin
						ex_status = ST_MISS;
					end
				end
				CMD_GET: begin
					if (!slot_ok) begin
						ex_status = ST_BAD_ARG;
					end else if (!hit_any) begin
						ex_status = ST_MISS;
					end else begin
						mem_re = slot_on;
					end
				end
				CMD_CLEAR: begin
					if (!slot_ok) begin
						ex_status = ST_BAD_ARG;
					end else if (!hit_any) begin
						ex_status = ST_MISS;
					end else begin
						valid_we  = 1'b1;
						valid_nxt = valid_q[hit_row] & ~slot_mask;
					end
				end
				CMD_CLEAR_ROW: begin
					if (!hit_any) begin
						ex_status = ST_MISS;
					end else begin
						key_we    = 1'b1;
						key_nxt   = 64'd0;
						valid_we  = 1'b1;
						valid_nxt = '0;
					end
				end
				default: begin
					ex_status = ST_BAD_ARG;
				end
			endcase
		end
	end

	// Sequence the request and update keys and enable bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
			for (int r = 0; r < ROWS; r++) begin
				key_q[r]   <= 64'd0;
				valid_q[r] <= '0;
			end
		end else begin
			// Raise the response when loaded, drop it once taken
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (exec_go) begin
						if (key_we) begin
							key_q[ex_row] <= key_nxt;
						end
						if (valid_we) begin
							valid_q[ex_row] <= valid_nxt;
						end
						if (mem_re) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Latch the request and load the response
	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (exec_go && !mem_re) begin
			rsp_q.status       <= ex_status;
			rsp_q.read_enabled <= 1'b0;
			rsp_q.read_payload <= 32'd0;
		end else if (state_q == S_READ) begin
			rsp_q.status       <= ST_DONE;
			rsp_q.read_enabled <= 1'b1;
			rsp_q.read_payload <= 32'(mem_rdata_q);
		end
	end

	// Payload memory: at most one write or one read per executed command
	always_ff @(posedge clk) begin
		if (exec_go && mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		if (exec_go && mem_re) begin
			mem_rdata_q <= mem[mem_addr];
		end
	end

	// A key never matches more than one row
	a_key_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC) && !id_zero |-> $onehot0(hit_vec))
		else $error("row key matched in more than one row");

	// Output register is empty when read data lands
	a_read_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |-> !rsp_valid_q)
		else $error("response register busy during memory read");

	// An accepted request enters the execute state next
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> (state_q == S_EXEC))
		else $error("accepted request not executed");

	// Only a successful get reports an enabled slot
	a_read_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && (rsp_q.status != ST_DONE) |-> !rsp_q.read_enabled)
		else $error("failed command returned read data");

	// A command finished without a memory read raises a response and returns to idle
	a_one_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		exec_go && !mem_re |=> rsp_valid_q && (state_q == S_IDLE))
		else $error("executed command produced no response");

endmodule

@@ tb/keyed_slot_table_unit_tb.sv @@
// Testbench for the keyed slot table: directed and random requests checked against a table model.
`timescale 1ns / 1ps

module keyed_slot_table_unit_tb;
	import kst_pkg::*;

	localparam int TBL_ROWS     = 8;
	localparam int TBL_SLOTS    = 7;
	localparam int POOL_SIZE    = 12;
	localparam int RANDOM_ITEMS = 1750;

	logic  clk;
	logic  arst_n;
	logic  req_valid;
	logic  req_stall;
	req_t  req;
	logic  rsp_valid;
	logic  rsp_stall;
	rsp_t  rsp;

	// Model of the table contents
	logic [63:0]          model_key [TBL_ROWS];
	logic [TBL_SLOTS-1:0] model_enable [TBL_ROWS];
	logic [31:0]          model_payload [TBL_ROWS][TBL_SLOTS];

	rsp_t        expected_rsp_q[$];
	logic [63:0] id_pool [POOL_SIZE];

	int n_errors;
	int n_sent;
	int n_done;
	int n_bad_arg;
	int n_miss;
	int n_read_hits;
	int hold_off_left;
	bit req_calm;
	bit rsp_calm;

	keyed_slot_table_unit #(
		.ROWS(TBL_ROWS),
		.SLOTS(TBL_SLOTS),
		.PAYLOAD_WIDTH(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// Clock: 10 ns period
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Work out the response of one request and update the model table
	function automatic rsp_t table_predict(req_t r);
		rsp_t o;
		int   hit;
		int   free_row;
		bit   slot_ok;
		o        = '0;
		hit      = -1;
		free_row = -1;
		for (int i = TBL_ROWS - 1; i >= 0; i--) begin
			if (model_key[i] == r.character_id)
				hit = i;
			if (model_key[i] == 64'd0)
				free_row = i;
		end
		slot_ok = (r.slot < TBL_SLOTS);
		if (r.character_id == 64'd0) begin
			o.status = ST_BAD_ARG;
		end else begin
			case (r.command)
				CMD_SET: begin
					if (!slot_ok || !r.choice_enabled) begin
						o.status = ST_BAD_ARG;
					end else begin
						// claim the lowest free row for an unknown id
						if (hit < 0 && free_row >= 0) begin
							hit = free_row;
							model_key[hit]    = r.character_id;
							model_enable[hit] = '0;
						end
						if (hit < 0) begin
							o.status = ST_MISS;
						end else begin
							model_enable[hit][r.slot]  = 1'b1;
							model_payload[hit][r.slot] = r.choice_payload;
						end
					end
				end
				CMD_GET: begin
					if (!slot_ok)
						o.status = ST_BAD_ARG;
					else if (hit < 0)
						o.status = ST_MISS;
					else if (model_enable[hit][r.slot]) begin
						o.read_enabled = 1'b1;
						o.read_payload = model_payload[hit][r.slot];
					end
				end
				CMD_CLEAR: begin
					if (!slot_ok)
						o.status = ST_BAD_ARG;
					else if (hit < 0)
						o.status = ST_MISS;
					else
						model_enable[hit][r.slot] = 1'b0;
				end
				default: begin
					// clear whole row; slot field is ignored
					if (hit < 0) begin
						o.status = ST_MISS;
					end else begin
						model_key[hit]    = 64'd0;
						model_enable[hit] = '0;
					end
				end
			endcase
		end
		return o;
	endfunction

	// Idle length: mostly short, a few long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 2);
		else if (r < 96)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	function automatic req_t make_req(logic [1:0] cmd, logic [63:0] id, logic [2:0] slot,
			logic en, logic [31:0] payload);
		req_t r;
		r.command        = cmd;
		r.character_id   = id;
		r.slot           = slot;
		r.choice_enabled = en;
		r.choice_payload = payload;
		return r;
	endfunction

	// Offer one request and wait until the table takes it
	task automatic send_request(req_t r);
		int gap;
		gap = req_calm ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req       <= r;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		expected_rsp_q.push_back(table_predict(r));
		n_sent++;
	endtask

	// Receiver: random stalls, with a long counted hold-off on request
	initial begin
		int run;
		rsp_stall = 1'b0;
		run       = 0;
		forever begin
			@(negedge clk);
			if (hold_off_left > 0) begin
				rsp_stall <= 1'b1;
				hold_off_left--;
			end else if (run > 0 && !rsp_calm) begin
				rsp_stall <= 1'b1;
				run--;
			end else begin
				rsp_stall <= 1'b0;
				run = rsp_calm ? 0 : pick_gap();
			end
		end
	end

	// Compare each response with the oldest expectation
	always @(posedge clk) begin
		rsp_t exp_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsp_q.size() == 0) begin
				$error("response with no request pending: status %0d", rsp.status);
				n_errors++;
			end else begin
				exp_rsp = expected_rsp_q.pop_front();
				if (rsp.status !== exp_rsp.status) begin
					$error("status: expected %0d, actual %0d", exp_rsp.status, rsp.status);
					n_errors++;
				end
				if (rsp.read_enabled !== exp_rsp.read_enabled) begin
					$error("read_enabled: expected %0d, actual %0d",
						exp_rsp.read_enabled, rsp.read_enabled);
					n_errors++;
				end
				if (rsp.read_payload !== exp_rsp.read_payload) begin
					$error("read_payload: expected %h, actual %h",
						exp_rsp.read_payload, rsp.read_payload);
					n_errors++;
				end
				case (exp_rsp.status)
					ST_DONE:    n_done++;
					ST_BAD_ARG: n_bad_arg++;
					default:    n_miss++;
				endcase
				if (exp_rsp.read_enabled)
					n_read_hits++;
			end
		end
	end

	// Zero id on every command, bad slot and disabled set
	task automatic test_argument_checks();
		send_request(make_req(CMD_SET, 64'd0, 3'd1, 1'b1, 32'h1234_5678));
		send_request(make_req(CMD_GET, 64'd0, 3'd1, 1'b1, 32'h0));
		send_request(make_req(CMD_CLEAR, 64'd0, 3'd1, 1'b0, 32'h0));
		send_request(make_req(CMD_CLEAR_ROW, 64'd0, 3'd0, 1'b0, 32'h0));
		send_request(make_req(CMD_SET, id_pool[0], 3'd7, 1'b1, 32'hdead_beef));
		send_request(make_req(CMD_SET, id_pool[0], 3'd2, 1'b0, 32'hdead_beef));
		send_request(make_req(CMD_GET, id_pool[0], 3'd7, 1'b0, 32'h0));
		send_request(make_req(CMD_CLEAR, id_pool[0], 3'd7, 1'b0, 32'h0));
	endtask

	// Get, clear and clear-row on an id that has no row
	task automatic test_missing_row();
		send_request(make_req(CMD_GET, id_pool[0], 3'd0, 1'b0, 32'h0));
		send_request(make_req(CMD_CLEAR, id_pool[0], 3'd0, 1'b0, 32'h0));
		send_request(make_req(CMD_CLEAR_ROW, id_pool[0], 3'd0, 1'b0, 32'h0));
	endtask

	// Store and read at the edge slots with extreme payloads
	task automatic test_slot_access();
		send_request(make_req(CMD_SET, id_pool[0], 3'd0, 1'b1, 32'hffff_ffff));
		send_request(make_req(CMD_SET, id_pool[0], 3'd6, 1'b1, 32'h0000_0000));
		send_request(make_req(CMD_GET, id_pool[0], 3'd0, 1'b1, 32'h0));
		send_request(make_req(CMD_GET, id_pool[0], 3'd6, 1'b0, 32'h0));
		send_request(make_req(CMD_GET, id_pool[0], 3'd3, 1'b0, 32'h0));
		send_request(make_req(CMD_CLEAR, id_pool[0], 3'd0, 1'b0, 32'h0));
		send_request(make_req(CMD_GET, id_pool[0], 3'd0, 1'b0, 32'h0));
	endtask

	// Fill every row, hit the full table, free one row and reclaim it
	task automatic test_table_full();
		for (int i = 1; i < TBL_ROWS; i++)
			send_request(make_req(CMD_SET, id_pool[i], 3'(i - 1), 1'b1, $urandom));
		send_request(make_req(CMD_SET, id_pool[TBL_ROWS], 3'd2, 1'b1, 32'h5555_aaaa));
		send_request(make_req(CMD_CLEAR_ROW, id_pool[0], 3'd7, 1'b0, 32'h0));
		send_request(make_req(CMD_SET, id_pool[TBL_ROWS], 3'd2, 1'b1, 32'haaaa_5555));
		send_request(make_req(CMD_GET, id_pool[TBL_ROWS], 3'd6, 1'b0, 32'h0));
	endtask

	// Random commands over a small id pool so rows get reused and the table fills
	task automatic test_random_traffic();
		req_t        r;
		int          pick;
		logic [63:0] id;
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			// alternate stretches with no idling on either side, and some with only the receiver never stalling
			req_calm = ((i / 128) % 4 == 1);
			rsp_calm = ((i / 128) % 4 == 1) || ((i / 128) % 4 == 3 && (i % 128) < 40);
			pick = $urandom_range(0, 99);
			if (pick < 90)
				id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
			else if (pick < 95)
				id = 64'd0;
			else
				id = {$urandom, $urandom};
			pick = $urandom_range(0, 99);
			if (pick < 40)
				r.command = CMD_SET;
			else if (pick < 75)
				r.command = CMD_GET;
			else if (pick < 90)
				r.command = CMD_CLEAR;
			else
				r.command = CMD_CLEAR_ROW;
			r.character_id   = id;
			r.slot           = ($urandom_range(0, 9) == 0) ? 3'd7 : 3'($urandom_range(0, 6));
			r.choice_enabled = ($urandom_range(0, 99) < 92);
			r.choice_payload = $urandom;
			send_request(r);
		end
		req_calm = 1'b0;
		rsp_calm = 1'b0;
	endtask

	// Hold off the receiver while requests keep coming, so the table backs up
	task automatic test_output_backpressure();
		req_calm      = 1'b1;
		hold_off_left = 400;
		for (int i = 0; i < 16; i++) begin
			if (i % 2 == 0)
				send_request(make_req(CMD_SET, id_pool[i % POOL_SIZE], 3'(i % TBL_SLOTS),
					1'b1, $urandom));
			else
				send_request(make_req(CMD_GET, id_pool[(i - 1) % POOL_SIZE],
					3'((i - 1) % TBL_SLOTS), 1'b0, 32'h0));
		end
		req_calm = 1'b0;
	endtask

	// Main sequence
	initial begin
		bit fresh;
		arst_n        = 1'b0;
		req_valid     = 1'b0;
		req           = '0;
		n_errors      = 0;
		n_sent        = 0;
		n_done        = 0;
		n_bad_arg     = 0;
		n_miss        = 0;
		n_read_hits   = 0;
		hold_off_left = 0;
		req_calm      = 1'b0;
		rsp_calm      = 1'b0;
		for (int i = 0; i < TBL_ROWS; i++) begin
			model_key[i]    = 64'd0;
			model_enable[i] = '0;
			for (int s = 0; s < TBL_SLOTS; s++)
				model_payload[i][s] = 32'd0;
		end
		// distinct nonzero ids; the first is all ones
		id_pool[0] = '1;
		for (int i = 1; i < POOL_SIZE; i++) begin
			do begin
				id_pool[i] = {$urandom, $urandom};
				fresh = (id_pool[i] != 64'd0);
				for (int j = 0; j < i; j++)
					if (id_pool[j] == id_pool[i])
						fresh = 1'b0;
			end while (!fresh);
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_argument_checks();
		test_missing_row();
		test_slot_access();
		test_table_full();
		test_random_traffic();
		test_output_backpressure();

		// Drain the remaining responses
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run covered %0d requests: %0d done, %0d rejected, %0d full or missing row,",
			n_sent, n_done, n_bad_arg, n_miss);
		$display("with %0d reads of enabled slots and %0d mismatches.", n_read_hits, n_errors);
		if (n_errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	// Timeout
	initial begin
		#10_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
